[rtl/crop_aspect_dimension_fix_unit_macros.svh]
// Assertion macros shared by the crop and aspect dimension fix unit.
`ifndef CROP_ASPECT_DIMENSION_FIX_UNIT_MACROS_SVH
`define CROP_ASPECT_DIMENSION_FIX_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CADF_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cadf assertion failed");

// Next-cycle implication, disabled during reset.
`define CADF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cadf assertion failed");

`endif

[rtl/cadf_pkg.sv]
// Types and constants of the crop and aspect dimension fix unit.
`default_nettype none
package cadf_pkg;

   localparam int SRC_W    = 13;
   localparam int ASP_W    = 8;
   localparam int DIM_IN_W = 13;
   localparam int DIM_W    = 14;
   localparam int CROP_IN_W = 14;
   localparam int CROP_W   = 11;
   localparam int OUT_W    = 16;
   localparam int QUO_W    = 17;
   localparam int NUM_W    = 48;
   localparam int DEN_W    = 34;
   localparam int P1_W     = DIM_W + SRC_W;
   localparam int P2_W     = ASP_W + SRC_W;
   localparam int D1_W     = SRC_W + ASP_W;

   localparam int CROP_CAP = 2046;
   localparam int DIM_MAX  = 65520;
   localparam int DIM_STEP = 16;

   localparam int DEF_ASPECT_BASE = 9;
   localparam int DEF_QUEUE_DEPTH = 2;

   localparam logic [SRC_W-1:0] RST_SRC_WIDTH  = 13'd720;
   localparam logic [SRC_W-1:0] RST_SRC_HEIGHT = 13'd576;
   localparam logic [ASP_W-1:0] RST_SRC_ASPECT = 8'd12;

   typedef enum logic [1:0] {
      CSR_SRC_WIDTH  = 2'd0,
      CSR_SRC_HEIGHT = 2'd1,
      CSR_SRC_ASPECT = 2'd2,
      CSR_UNUSED     = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [SRC_W-1:0] src_width;
      logic [SRC_W-1:0] src_height;
      logic [ASP_W-1:0] src_aspect;
   } cfg_type;

   // Fields that pass through the arithmetic untouched.
   typedef struct packed {
      logic              keep_width;
      logic [DIM_W-1:0]  width;
      logic [DIM_W-1:0]  height;
      logic [CROP_W-1:0] top;
      logic [CROP_W-1:0] bottom;
      logic [CROP_W-1:0] left;
      logic [CROP_W-1:0] right;
   } meta_type;

   // Classified request: the operands of the ratio.
   typedef struct packed {
      meta_type          meta;
      logic [DIM_W-1:0]  dim;
      logic [SRC_W-1:0]  src;
      logic [ASP_W-1:0]  fac_n;
      logic [SRC_W-1:0]  span_n;
      logic [SRC_W-1:0]  src_d;
      logic [ASP_W-1:0]  fac_d;
      logic [SRC_W-1:0]  span_d;
   } entry_type;

   typedef struct packed {
      logic [7:0] count;
   } queue_stat_type;

endpackage
`default_nettype wire

[rtl/cadf_front.sv]
// Front end: rounds the dimensions, clamps the crops and picks the ratio operands.
`default_nettype none
module cadf_front
   import cadf_pkg::*;
#(
   parameter int ASPECT_BASE = DEF_ASPECT_BASE
) (
   input  wire cfg_type                 cfg,
   input  wire logic                    keep_width,
   input  wire logic [DIM_IN_W-1:0]     req_width,
   input  wire logic [DIM_IN_W-1:0]     req_height,
   input  wire logic [CROP_IN_W-1:0]    crop_top,
   input  wire logic [CROP_IN_W-1:0]    crop_bottom,
   input  wire logic [CROP_IN_W-1:0]    crop_left,
   input  wire logic [CROP_IN_W-1:0]    crop_right,
   output entry_type                    entry
);

   localparam logic [ASP_W-1:0] BASE = ASP_W'(ASPECT_BASE);

   function automatic logic [DIM_W-1:0] round_dim(input logic [DIM_IN_W-1:0] v);
      logic [DIM_W-1:0] r;
      r = (DIM_W'(v) + DIM_W'(8)) & ~DIM_W'(15);
      if (r < DIM_W'(DIM_STEP))
         r = DIM_W'(DIM_STEP);
      return r;
   endfunction

   function automatic logic [CROP_W-1:0] limit_of(input logic [SRC_W-1:0] src);
      logic [SRC_W-2:0] half;
      logic [SRC_W-2:0] lim;
      half = src[SRC_W-1:1];
      lim  = (half < (SRC_W-1)'(2)) ? '0 : half - (SRC_W-1)'(2);
      if (lim > (SRC_W-1)'(CROP_CAP))
         lim = (SRC_W-1)'(CROP_CAP);
      return lim[CROP_W-1:0];
   endfunction

   function automatic logic [CROP_W-1:0] fix_crop(input logic [CROP_IN_W-1:0] raw,
                                                  input logic [CROP_W-1:0] lim);
      logic [CROP_IN_W-1:0] ev;
      logic [CROP_W-1:0]    c;
      ev = raw + CROP_IN_W'(raw[0]);
      if (raw[CROP_IN_W-1] || raw == '0)
         c = '0;
      else if (ev > CROP_IN_W'(lim))
         c = lim;
      else
         c = ev[CROP_W-1:0];
      return c;
   endfunction

   function automatic logic [SRC_W-1:0] span_of(input logic [SRC_W-1:0] src,
                                               input logic [CROP_W-1:0] a,
                                               input logic [CROP_W-1:0] b);
      logic [CROP_W:0] sum;
      sum = (CROP_W+1)'(a) + (CROP_W+1)'(b);
      return (SRC_W'(sum) <= src) ? src - SRC_W'(sum) : '0;
   endfunction

   logic [CROP_W-1:0] vlim, hlim;
   logic [SRC_W-1:0]  span_v, span_h;
   meta_type          meta;

   always_comb begin
      vlim = limit_of(cfg.src_height);
      hlim = limit_of(cfg.src_width);
      meta.keep_width = keep_width;
      meta.width  = round_dim(req_width);
      meta.height = round_dim(req_height);
      meta.top    = fix_crop(crop_top, vlim);
      meta.bottom = fix_crop(crop_bottom, vlim);
      meta.left   = fix_crop(crop_left, hlim);
      meta.right  = fix_crop(crop_right, hlim);
      span_v = span_of(cfg.src_height, meta.top, meta.bottom);
      span_h = span_of(cfg.src_width, meta.left, meta.right);
      entry.meta = meta;
      if (keep_width) begin
         entry.dim    = meta.width;
         entry.src    = cfg.src_width;
         entry.fac_n  = BASE;
         entry.span_n = span_v;
         entry.src_d  = cfg.src_height;
         entry.fac_d  = cfg.src_aspect;
         entry.span_d = span_h;
      end else begin
         entry.dim    = meta.height;
         entry.src    = cfg.src_height;
         entry.fac_n  = cfg.src_aspect;
         entry.span_n = span_h;
         entry.src_d  = cfg.src_width;
         entry.fac_d  = BASE;
         entry.span_d = span_v;
      end
   end

endmodule
`default_nettype wire

[rtl/cadf_queue.sv]
// Short register queue between the front end and the arithmetic back end.
`default_nettype none
module cadf_queue
   import cadf_pkg::*;
#(
   parameter int DEPTH = DEF_QUEUE_DEPTH
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      wr_valid,
   output logic           wr_ready,
   input  wire entry_type wr_data,
   output logic           rd_valid,
   input  wire logic      rd_ready,
   output entry_type      rd_data,
   output queue_stat_type stat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type          mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push, pop;

   assign wr_ready = (count_ff < CNT_W'(DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data  = mem_ff[rd_ptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;
   assign stat.count = 8'(count_ff);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push)
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      if (pop)
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      if (push && !pop)
         count_in = count_ff + CNT_W'(1);
      else if (pop && !push)
         count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         mem_ff[wr_ptr_ff] <= wr_data;
   end

endmodule
`default_nettype wire

[rtl/cadf_back.sv]
// Back end: multiplier stages, pipelined restoring divider and final rounding.
`default_nettype none
module cadf_back
   import cadf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   output logic             in_ready,
   input  wire entry_type   in_data,
   output logic             out_valid,
   input  wire logic        out_ready,
   output logic [OUT_W-1:0] out_width,
   output logic [OUT_W-1:0] out_height,
   output logic [CROP_W-1:0] out_top,
   output logic [CROP_W-1:0] out_bottom,
   output logic [CROP_W-1:0] out_left,
   output logic [CROP_W-1:0] out_right
);

   localparam int NSTG = QUO_W + 1;
   localparam int TRY_W = DEN_W + QUO_W;

   typedef struct packed {
      meta_type          meta;
      logic              zero;
      logic              sat;
      logic [NUM_W-1:0]  rem;
      logic [DEN_W-1:0]  den;
      logic [QUO_W-1:0]  quo;
   } div_type;

   logic              adv;

   logic              v0_ff, v1_ff;
   meta_type          m0_ff, m1_ff;
   logic [P1_W-1:0]   p1_ff;
   logic [P2_W-1:0]   p2_ff;
   logic [D1_W-1:0]   d1_ff;
   logic [SRC_W-1:0]  sd_ff;
   logic [NUM_W-1:0]  num_ff;
   logic [DEN_W-1:0]  den_ff;

   logic              dv_v_ff [NSTG];
   div_type           dv_ff   [NSTG];

   logic              ov_ff;
   logic [OUT_W-1:0]  ow_ff, oh_ff;
   meta_type          om_ff;
   logic [OUT_W-1:0]  comp;

   assign adv      = !ov_ff || out_ready;
   assign in_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= in_valid;
         v1_ff <= v0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m0_ff  <= in_data.meta;
         p1_ff  <= P1_W'(in_data.dim) * P1_W'(in_data.src);
         p2_ff  <= P2_W'(in_data.fac_n) * P2_W'(in_data.span_n);
         d1_ff  <= D1_W'(in_data.src_d) * D1_W'(in_data.fac_d);
         sd_ff  <= in_data.span_d;
         m1_ff  <= m0_ff;
         num_ff <= NUM_W'(p1_ff) * NUM_W'(p2_ff);
         den_ff <= DEN_W'(d1_ff) * DEN_W'(sd_ff);
      end
   end

   // Divider entry: a quotient of 2^17 or more always saturates the output.
   always_ff @(posedge clock) begin
      if (reset)
         dv_v_ff[0] <= 1'b0;
      else if (adv)
         dv_v_ff[0] <= v1_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_ff[0].meta <= m1_ff;
         dv_ff[0].zero <= (den_ff == '0);
         dv_ff[0].sat  <= ((TRY_W+1)'(num_ff) >= ((TRY_W+1)'(den_ff) << QUO_W));
         dv_ff[0].rem  <= num_ff;
         dv_ff[0].den  <= den_ff;
         dv_ff[0].quo  <= '0;
      end
   end

   for (genvar k = 0; k < QUO_W; k++) begin : g_div
      localparam int B = QUO_W - 1 - k;
      logic [TRY_W-1:0] trial;
      div_type          nxt;

      always_comb begin
         trial = TRY_W'(dv_ff[k].den) << B;
         nxt   = dv_ff[k];
         if (TRY_W'(dv_ff[k].rem) >= trial) begin
            nxt.rem    = dv_ff[k].rem - NUM_W'(trial);
            nxt.quo[B] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset)
            dv_v_ff[k+1] <= 1'b0;
         else if (adv)
            dv_v_ff[k+1] <= dv_v_ff[k];
      end

      always_ff @(posedge clock) begin
         if (adv)
            dv_ff[k+1] <= nxt;
      end
   end

   always_comb begin
      logic [QUO_W:0] rnd;
      rnd = ((QUO_W+1)'(dv_ff[NSTG-1].quo) + (QUO_W+1)'(8)) & ~(QUO_W+1)'(15);
      if (dv_ff[NSTG-1].zero)
         comp = OUT_W'(DIM_STEP);
      else if (dv_ff[NSTG-1].sat || rnd > (QUO_W+1)'(DIM_MAX))
         comp = OUT_W'(DIM_MAX);
      else if (rnd < (QUO_W+1)'(DIM_STEP))
         comp = OUT_W'(DIM_STEP);
      else
         comp = rnd[OUT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset)
         ov_ff <= 1'b0;
      else if (adv)
         ov_ff <= dv_v_ff[NSTG-1];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         om_ff <= dv_ff[NSTG-1].meta;
         ow_ff <= dv_ff[NSTG-1].meta.keep_width ? OUT_W'(dv_ff[NSTG-1].meta.width) : comp;
         oh_ff <= dv_ff[NSTG-1].meta.keep_width ? comp : OUT_W'(dv_ff[NSTG-1].meta.height);
      end
   end

   assign out_valid  = ov_ff;
   assign out_width  = ow_ff;
   assign out_height = oh_ff;
   assign out_top    = om_ff.top;
   assign out_bottom = om_ff.bottom;
   assign out_left   = om_ff.left;
   assign out_right  = om_ff.right;

endmodule
`default_nettype wire

[rtl/crop_aspect_dimension_fix_unit.sv]
// Top level of the crop and aspect dimension fix unit.
//
//   Channel  Direction  Handshake            Contents
//   req      in         req_valid/req_ready  keep flag, requested size, four crops
//   rsp      out        rsp_valid/rsp_ready  final size, four clamped crops
//   csr      in         csr_we               source width, height and aspect
//
// One request is taken every cycle while the queue has room. A request's result
// passes through the queue register, two multiplier stages, the divider entry
// stage, the 17-stage restoring divider that forms the free dimension and the
// result register.
// Reset is synchronous and active high; it empties the queue and the pipeline
// and loads the source registers with 720 by 576 at aspect 12.
// A stalled result freezes the whole back end; the queue keeps taking requests
// until it is full, so the front end stalls only after that.
`default_nettype none
`include "crop_aspect_dimension_fix_unit_macros.svh"
module crop_aspect_dimension_fix_unit
   import cadf_pkg::*;
#(
   parameter int ASPECT_BASE = DEF_ASPECT_BASE,
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_keep_width,
   input  wire logic [DIM_IN_W-1:0]  req_req_width,
   input  wire logic [DIM_IN_W-1:0]  req_req_height,
   input  wire logic [CROP_IN_W-1:0] req_crop_top,
   input  wire logic [CROP_IN_W-1:0] req_crop_bottom,
   input  wire logic [CROP_IN_W-1:0] req_crop_left,
   input  wire logic [CROP_IN_W-1:0] req_crop_right,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [OUT_W-1:0]          rsp_out_width,
   output logic [OUT_W-1:0]          rsp_out_height,
   output logic [CROP_W-1:0]         rsp_top_crop,
   output logic [CROP_W-1:0]         rsp_bottom_crop,
   output logic [CROP_W-1:0]         rsp_left_crop,
   output logic [CROP_W-1:0]         rsp_right_crop,
   input  wire logic                 csr_we,
   input  wire logic [1:0]           csr_index,
   input  wire logic [SRC_W-1:0]     csr_wdata
);

   cfg_type        cfg_ff;
   entry_type      front_entry;
   entry_type      queue_head;
   logic           queue_valid;
   logic           back_ready;
   queue_stat_type q_stat;
   logic           size_ok;
   logic           fill_empty;

   // Source registers; writes to an unused index are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.src_width  <= RST_SRC_WIDTH;
         cfg_ff.src_height <= RST_SRC_HEIGHT;
         cfg_ff.src_aspect <= RST_SRC_ASPECT;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_SRC_WIDTH:  cfg_ff.src_width  <= csr_wdata;
            CSR_SRC_HEIGHT: cfg_ff.src_height <= csr_wdata;
            CSR_SRC_ASPECT: cfg_ff.src_aspect <= csr_wdata[ASP_W-1:0];
            default: ;
         endcase
      end
   end

   // The front end is combinational: each request is classified on its way
   // into the queue.
   cadf_front #(
      .ASPECT_BASE (ASPECT_BASE)
   ) u_front (
      .cfg         (cfg_ff),
      .keep_width  (req_keep_width),
      .req_width   (req_req_width),
      .req_height  (req_req_height),
      .crop_top    (req_crop_top),
      .crop_bottom (req_crop_bottom),
      .crop_left   (req_crop_left),
      .crop_right  (req_crop_right),
      .entry       (front_entry)
   );

   cadf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (req_valid),
      .wr_ready (req_ready),
      .wr_data  (front_entry),
      .rd_valid (queue_valid),
      .rd_ready (back_ready),
      .rd_data  (queue_head),
      .stat     (q_stat)
   );

   cadf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (queue_valid),
      .in_ready   (back_ready),
      .in_data    (queue_head),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_width  (rsp_out_width),
      .out_height (rsp_out_height),
      .out_top    (rsp_top_crop),
      .out_bottom (rsp_bottom_crop),
      .out_left   (rsp_left_crop),
      .out_right  (rsp_right_crop)
   );

   assign size_ok = rsp_out_width[3:0] == 4'd0 && rsp_out_height[3:0] == 4'd0
                    && rsp_out_width != '0 && rsp_out_height != '0;
   assign fill_empty = req_valid && req_ready && q_stat.count == 8'd0;

   // The queue never holds more than its depth.
   `CADF_ASSERT_IMPLIES(a_queue_bound, clock, reset, 1'b1, q_stat.count <= 8'(QUEUE_DEPTH))
   // Every result size is a non-zero multiple of sixteen.
   `CADF_ASSERT_IMPLIES(a_size_step, clock, reset, rsp_valid, size_ok)
   // A request taken into an empty queue is visible at its head next cycle.
   `CADF_ASSERT_NEXT(a_queue_fill, clock, reset, fill_empty, queue_valid)

endmodule
`default_nettype wire

[sim/tb_crop_aspect_dimension_fix_unit.sv]
// Self-checking testbench for the crop and aspect dimension fix unit.
`timescale 1ns / 1ps
`default_nettype none
module tb_crop_aspect_dimension_fix_unit
   import cadf_pkg::*;
;

   // Fields of one request, and of one result, as the block sees them.
   typedef struct {
      logic                 keep_width;
      logic [DIM_IN_W-1:0]  width;
      logic [DIM_IN_W-1:0]  height;
      logic [CROP_IN_W-1:0] crop [4];
   } fix_request_type;

   typedef struct {
      logic [OUT_W-1:0]  width;
      logic [OUT_W-1:0]  height;
      logic [CROP_W-1:0] crop [4];
   } fix_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_keep_width = 1'b0;
   logic [DIM_IN_W-1:0]  req_req_width = '0;
   logic [DIM_IN_W-1:0]  req_req_height = '0;
   logic [CROP_IN_W-1:0] req_crop_top = '0;
   logic [CROP_IN_W-1:0] req_crop_bottom = '0;
   logic [CROP_IN_W-1:0] req_crop_left = '0;
   logic [CROP_IN_W-1:0] req_crop_right = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [OUT_W-1:0]     rsp_out_width;
   logic [OUT_W-1:0]     rsp_out_height;
   logic [CROP_W-1:0]    rsp_top_crop;
   logic [CROP_W-1:0]    rsp_bottom_crop;
   logic [CROP_W-1:0]    rsp_left_crop;
   logic [CROP_W-1:0]    rsp_right_crop;
   logic                 csr_we = 1'b0;
   logic [1:0]           csr_index = '0;
   logic [SRC_W-1:0]     csr_wdata = '0;

   crop_aspect_dimension_fix_unit dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // The testbench's own copy of the source registers.
   logic [SRC_W-1:0] src_width_q;
   logic [SRC_W-1:0] src_height_q;
   logic [ASP_W-1:0] src_aspect_q;

   fix_result_type expected_fixes [$];
   int             mismatch_count = 0;
   int             idle_cycles = 0;
   // When set, the receiver holds rsp_ready low so that the queue fills up.
   bit             hold_results = 1'b0;

   // Rounds to the nearest multiple of 16, halves upwards, between 16 and 65520.
   function automatic longint unsigned snap_dimension(longint unsigned v);
      longint unsigned r;
      r = ((v + 8) / DIM_STEP) * DIM_STEP;
      if (r < DIM_STEP) r = DIM_STEP;
      if (r > DIM_MAX) r = DIM_MAX;
      return r;
   endfunction

   // The largest crop that a source dimension allows, capped to fit 11 bits.
   function automatic longint crop_ceiling(longint unsigned src);
      longint c;
      c = longint'(src / 2) - 2;
      if (c < 0) c = 0;
      if (c > CROP_CAP) c = CROP_CAP;
      return c;
   endfunction

   // A negative or zero crop becomes 0; an odd one is rounded up to even and
   // then clamped, which may leave it odd when the ceiling itself is odd.
   function automatic longint unsigned clamp_crop(logic [CROP_IN_W-1:0] raw,
                                                  longint ceiling);
      longint c;
      c = longint'(signed'(raw));
      if (c <= 0) return 0;
      c += c & 1;
      if (c > ceiling) c = ceiling;
      return longint'(c);
   endfunction

   function automatic fix_result_type predict_fix(fix_request_type r);
      fix_result_type  res;
      longint unsigned w, h, vlim, hlim, ct, cb, cl, cr, span_v, span_h, num, den;
      w = snap_dimension(r.width);
      h = snap_dimension(r.height);
      vlim = crop_ceiling(src_height_q);
      hlim = crop_ceiling(src_width_q);
      ct = clamp_crop(r.crop[0], vlim);
      cb = clamp_crop(r.crop[1], vlim);
      cl = clamp_crop(r.crop[2], hlim);
      cr = clamp_crop(r.crop[3], hlim);
      span_v = (ct + cb <= src_height_q) ? src_height_q - ct - cb : 0;
      span_h = (cl + cr <= src_width_q) ? src_width_q - cl - cr : 0;
      // The free dimension keeps the source aspect over the cropped area.
      if (r.keep_width) begin
         num = w * src_width_q * DEF_ASPECT_BASE * span_v;
         den = src_height_q * src_aspect_q * span_h;
         h = (den == 0) ? DIM_STEP : snap_dimension(num / den);
      end else begin
         num = h * src_height_q * src_aspect_q * span_h;
         den = src_width_q * DEF_ASPECT_BASE * span_v;
         w = (den == 0) ? DIM_STEP : snap_dimension(num / den);
      end
      res.width = w[OUT_W-1:0];
      res.height = h[OUT_W-1:0];
      res.crop[0] = ct[CROP_W-1:0];
      res.crop[1] = cb[CROP_W-1:0];
      res.crop[2] = cl[CROP_W-1:0];
      res.crop[3] = cr[CROP_W-1:0];
      return res;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("Mismatch on %s: got %0d, expected %0d", what, got, want);
      mismatch_count++;
   endtask

   // Writes one source register while the block is idle; the caller lowers
   // the write enable after its last write.
   task automatic write_source(csr_index_type idx, logic [SRC_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_SRC_WIDTH: begin
            src_width_q = value;
         end
         CSR_SRC_HEIGHT: begin
            src_height_q = value;
         end
         CSR_SRC_ASPECT: begin
            src_aspect_q = value[ASP_W-1:0];
         end
         default: begin
         end
      endcase
   endtask

   task automatic set_source(logic [SRC_W-1:0] w, logic [SRC_W-1:0] h,
                             logic [ASP_W-1:0] a);
      write_source(CSR_SRC_WIDTH, w);
      write_source(CSR_SRC_HEIGHT, h);
      write_source(CSR_SRC_ASPECT, {5'd0, a});
      csr_we <= 1'b0;
   endtask

   // Sends one request after a random gap if with_gap is set and records its expected result.
   // The caller is at a rising edge; so is this task when it returns. Valid
   // stays high after acceptance until the next gap or until wait_idle.
   task automatic send_request(fix_request_type r, bit with_gap = 1'b1);
      int gap;
      gap = with_gap ? $urandom_range(0, 5) : 0;
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_keep_width <= r.keep_width;
      req_req_width <= r.width;
      req_req_height <= r.height;
      req_crop_top <= r.crop[0];
      req_crop_bottom <= r.crop[1];
      req_crop_left <= r.crop[2];
      req_crop_right <= r.crop[3];
      do @(posedge clock); while (!req_ready);
      expected_fixes.push_back(predict_fix(r));
   endtask

   // Waits until every expected result has come, then lets the pipeline drain.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_fixes.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   function automatic logic [CROP_IN_W-1:0] random_crop();
      case ($urandom_range(0, 5))
         0: return CROP_IN_W'($urandom_range(0, 16383));
         1: return CROP_IN_W'(-$urandom_range(0, 4096));
         2: return CROP_IN_W'($urandom_range(0, 40));
         default: return CROP_IN_W'($urandom_range(0, 4096));
      endcase
   endfunction

   function automatic fix_request_type random_request();
      fix_request_type r;
      r.keep_width = 1'($urandom_range(0, 1));
      // Mostly sensible sizes; now and then any 13-bit value.
      r.width = ($urandom_range(0, 7) == 0) ? DIM_IN_W'($urandom_range(0, 8191))
                                               : DIM_IN_W'($urandom_range(0, 4096));
      r.height = ($urandom_range(0, 7) == 0) ? DIM_IN_W'($urandom_range(0, 8191))
                                                : DIM_IN_W'($urandom_range(0, 4096));
      foreach (r.crop[i]) r.crop[i] = random_crop();
      return r;
   endfunction

   function automatic fix_request_type make_request(bit k, int w, int h, int t, int b,
                                                    int l, int rt);
      fix_request_type r;
      r.keep_width = k;
      r.width = DIM_IN_W'(w);
      r.height = DIM_IN_W'(h);
      r.crop[0] = CROP_IN_W'(t);
      r.crop[1] = CROP_IN_W'(b);
      r.crop[2] = CROP_IN_W'(l);
      r.crop[3] = CROP_IN_W'(rt);
      return r;
   endfunction

   // Directed cases at the reset source: field extremes, both modes, rounding.
   task automatic test_directed_extremes();
      send_request(make_request(1, 0, 0, 0, 0, 0, 0));
      send_request(make_request(0, 0, 0, 0, 0, 0, 0));
      send_request(make_request(1, 4096, 4096, 4096, 4096, 4096, 4096));
      send_request(make_request(0, 4096, 4096, -4096, -4096, -4096, -4096));
      send_request(make_request(1, 8191, 8191, 8191, -8192, 1, 3));
      send_request(make_request(0, 8191, 8191, -1, 8191, 7, 5));
      send_request(make_request(1, 7, 24, 1, 2, 3, 4));
      send_request(make_request(0, 8, 23, 9, 11, 13, 15));
      send_request(make_request(1, 720, 576, 16383, 2047, 4095, 1023));
      send_request(make_request(0, 720, 576, 100, 101, 200, 201));
   endtask

   // Odd ceilings, tiny and large sources, zero divisors and saturation.
   task automatic test_source_corners();
      // Half of 22 minus 2 is 9, so a clamped crop stays odd.
      set_source(13'd22, 13'd30, 8'd12);
      send_request(make_request(1, 64, 64, 4096, 3, 4096, 9));
      send_request(make_request(0, 64, 64, 13, 4096, 1, 4096));
      wait_idle();
      // A tiny source: every crop is clamped to 0.
      set_source(13'd2, 13'd3, 8'd1);
      send_request(make_request(1, 4096, 16, 50, 50, 50, 50));
      send_request(make_request(0, 16, 4096, 50, 50, 50, 50));
      wait_idle();
      // Zero source and zero aspect give a zero divisor.
      set_source(13'd0, 13'd0, 8'd0);
      send_request(make_request(1, 320, 240, 4, 4, 4, 4));
      send_request(make_request(0, 320, 240, 4, 4, 4, 4));
      wait_idle();
      // The largest source caps the crop ceiling; saturation on a wide result.
      set_source(13'd8191, 13'd8191, 8'd255);
      send_request(make_request(0, 4096, 4096, 4096, 4096, 0, 0));
      send_request(make_request(1, 4096, 4096, 0, 0, 4096, 4096));
      wait_idle();
      set_source(13'd16, 13'd4096, 8'd1);
      send_request(make_request(1, 4096, 16, 0, 0, 0, 0));
      send_request(make_request(0, 16, 4096, 2046, 2046, 0, 0));
      wait_idle();
   endtask

   // Random requests over several source settings, the extremes among them.
   task automatic test_random_sources();
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: set_source(13'd720, 13'd576, 8'd12);
            1: set_source(13'd16, 13'd16, 8'd1);
            2: set_source(13'd4096, 13'd4096, 8'd255);
            3: set_source(13'd1920, 13'd1080, 8'd16);
            default: set_source(SRC_W'($urandom_range(0, 8191)),
                                SRC_W'($urandom_range(0, 8191)),
                                ASP_W'($urandom_range(0, 255)));
         endcase
         for (int i = 0; i < 90; i++) send_request(random_request());
         wait_idle();
      end
   endtask

   // The receiver holds off while requests keep coming, so the queue fills up.
   task automatic test_back_pressure();
      set_source(13'd1280, 13'd720, 8'd16);
      hold_results = 1'b1;
      fork
         begin
            repeat (80) @(posedge clock);
            hold_results = 1'b0;
         end
      join_none
      for (int i = 0; i < 60; i++) send_request(random_request(), 1'b0);
      wait_idle();
   endtask

   // Result checker and random receiver stalls.
   initial begin
      int stall;
      fix_result_type want;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            if (expected_fixes.size() == 0) begin
               report_mismatch("unexpected result", 1, 0);
            end else begin
               want = expected_fixes.pop_front();
               if (rsp_out_width != want.width)
                  report_mismatch("out_width", rsp_out_width, want.width);
               if (rsp_out_height != want.height)
                  report_mismatch("out_height", rsp_out_height, want.height);
               if (rsp_top_crop != want.crop[0])
                  report_mismatch("top_crop", rsp_top_crop, want.crop[0]);
               if (rsp_bottom_crop != want.crop[1])
                  report_mismatch("bottom_crop", rsp_bottom_crop, want.crop[1]);
               if (rsp_left_crop != want.crop[2])
                  report_mismatch("left_crop", rsp_left_crop, want.crop[2]);
               if (rsp_right_crop != want.crop[3])
                  report_mismatch("right_crop", rsp_right_crop, want.crop[3]);
            end
         end
         if (reset || hold_results) begin
            rsp_ready <= 1'b0;
         end else if (rsp_ready && rsp_valid || !rsp_ready) begin
            // A fresh wait is drawn for each result; at least one in three has none.
            stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
            if (stall == 0) begin
               rsp_ready <= 1'b1;
            end else begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
               rsp_ready <= 1'b1;
            end
         end
      end
   end

   // Watchdog: counts cycles in which no request and no result is accepted.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles > 5000) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      src_width_q = RST_SRC_WIDTH;
      src_height_q = RST_SRC_HEIGHT;
      src_aspect_q = RST_SRC_ASPECT;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_extremes();
      wait_idle();
      test_source_corners();
      test_random_sources();
      test_back_pressure();
      wait_idle();
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

[sim.f]
+incdir+rtl
rtl/cadf_pkg.sv
rtl/cadf_front.sv
rtl/cadf_queue.sv
rtl/cadf_back.sv
rtl/crop_aspect_dimension_fix_unit.sv
sim/tb_crop_aspect_dimension_fix_unit.sv
